FILE: sv/yuv411_to_rgb_converter_defines.svh
// ---------------------------------------------------------------------------
// yuv411_to_rgb_converter_defines
// Assertion macros shared by the checker of the 4:1:1 to RGB converter.
// ---------------------------------------------------------------------------
`ifndef YUV411_TO_RGB_CONVERTER_DEFINES_SVH
`define YUV411_TO_RGB_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define YUV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define YUV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/yuv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// yuv2rgb_pkg
// Item types, coefficients and the output clamp of the 4:1:1 converter.
// ---------------------------------------------------------------------------
package yuv2rgb_pkg;

    // widest signed sum is below 2^26, one spare bit
    localparam int SUM_W   = 28;
    localparam int Q_W     = SUM_W - 16;
    localparam int LANES   = 4;
    localparam int PIX_MAX = 255;

    localparam logic signed [SUM_W-1:0] COEF_Y   = 76310;
    localparam logic signed [SUM_W-1:0] COEF_R_V = 104635;
    localparam logic signed [SUM_W-1:0] COEF_G_U = -25690;
    localparam logic signed [SUM_W-1:0] COEF_G_V = -53294;
    localparam logic signed [SUM_W-1:0] COEF_B_U = 132278;

    localparam logic [8:0] LUMA_OFFSET = 9'd16;

    typedef struct packed {
        logic [7:0] luma_0;
        logic [7:0] luma_1;
        logic [7:0] luma_2;
        logic [7:0] luma_3;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_0;
        logic [7:0] green_0;
        logic [7:0] blue_0;
        logic [7:0] red_1;
        logic [7:0] green_1;
        logic [7:0] blue_1;
        logic [7:0] red_2;
        logic [7:0] green_2;
        logic [7:0] blue_2;
        logic [7:0] red_3;
        logic [7:0] green_3;
        logic [7:0] blue_3;
    } t_out_item;

    // chroma products shared by all lanes
    typedef struct packed {
        logic signed [SUM_W-1:0] rv;
        logic signed [SUM_W-1:0] gu;
        logic signed [SUM_W-1:0] gv;
        logic signed [SUM_W-1:0] bu;
    } t_chroma_terms;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // floor by 2^16, then clamp to 0..255
    function automatic logic [7:0] clamp_px(input logic signed [SUM_W-1:0] s);
        logic signed [Q_W-1:0] q;
        logic [7:0]            px;
        q = s[SUM_W-1:16];
        if (q < 0) begin
            px = 8'd0;
        end else if (q > PIX_MAX) begin
            px = 8'(PIX_MAX);
        end else begin
            px = q[7:0];
        end
        return px;
    endfunction

endpackage

FILE: sv/yuv2rgb_chroma.sv
// ---------------------------------------------------------------------------
// yuv2rgb_chroma
// Registers the Cb/Cr products that the four pixel lanes share.
// ---------------------------------------------------------------------------
module yuv2rgb_chroma (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [7:0]                 i_cb,
    input  logic [7:0]                 i_cr,
    output yuv2rgb_pkg::t_chroma_terms o_terms
);
    import yuv2rgb_pkg::*;

    logic signed [7:0]       u;
    logic signed [7:0]       v;
    logic signed [SUM_W-1:0] u_ext;
    logic signed [SUM_W-1:0] v_ext;
    t_chroma_terms           n_terms;
    t_chroma_terms           r_terms;

    // flipping the top bit subtracts 128
    assign u     = $signed(i_cb ^ 8'h80);
    assign v     = $signed(i_cr ^ 8'h80);
    assign u_ext = {{(SUM_W-8){u[7]}}, u};
    assign v_ext = {{(SUM_W-8){v[7]}}, v};

    always_comb begin
        n_terms.rv = v_ext * COEF_R_V;
        n_terms.gu = u_ext * COEF_G_U;
        n_terms.gv = v_ext * COEF_G_V;
        n_terms.bu = u_ext * COEF_B_U;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

FILE: sv/yuv2rgb_lane.sv
// ---------------------------------------------------------------------------
// yuv2rgb_lane
// One pixel: registered luma product, then chroma sums and clamp.
// ---------------------------------------------------------------------------
module yuv2rgb_lane (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [7:0]                 i_luma,
    input  yuv2rgb_pkg::t_chroma_terms i_terms,
    output yuv2rgb_pkg::t_pixel        o_pixel
);
    import yuv2rgb_pkg::*;

    logic [8:0]              y;
    logic signed [SUM_W-1:0] y_ext;
    logic signed [SUM_W-1:0] n_ly;
    logic signed [SUM_W-1:0] r_ly;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;

    assign y     = {1'b0, i_luma} - LUMA_OFFSET;
    assign y_ext = {{(SUM_W-9){y[8]}}, y};
    assign n_ly  = y_ext * COEF_Y;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ly <= n_ly;
        end
    end

    assign sum_r = i_terms.rv + r_ly;
    assign sum_g = i_terms.gu + i_terms.gv + r_ly;
    assign sum_b = i_terms.bu + r_ly;

    always_comb begin
        o_pixel.red   = clamp_px(sum_r);
        o_pixel.green = clamp_px(sum_g);
        o_pixel.blue  = clamp_px(sum_b);
    end

endmodule

FILE: sv/yuv2rgb_merge.sv
// ---------------------------------------------------------------------------
// yuv2rgb_merge
// Gathers the four lane pixels into the registered output item.
// ---------------------------------------------------------------------------
module yuv2rgb_merge (
    input  logic                                         i_clk,
    input  logic                                         i_load,
    input  yuv2rgb_pkg::t_pixel [yuv2rgb_pkg::LANES-1:0] i_pixels,
    output yuv2rgb_pkg::t_out_item                       o_item
);
    import yuv2rgb_pkg::*;

    t_out_item n_item;
    t_out_item r_item;

    always_comb begin
        n_item.red_0   = i_pixels[0].red;
        n_item.green_0 = i_pixels[0].green;
        n_item.blue_0  = i_pixels[0].blue;
        n_item.red_1   = i_pixels[1].red;
        n_item.green_1 = i_pixels[1].green;
        n_item.blue_1  = i_pixels[1].blue;
        n_item.red_2   = i_pixels[2].red;
        n_item.green_2 = i_pixels[2].green;
        n_item.blue_2  = i_pixels[2].blue;
        n_item.red_3   = i_pixels[3].red;
        n_item.green_3 = i_pixels[3].green;
        n_item.blue_3  = i_pixels[3].blue;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

FILE: sv/yuv411_to_rgb_converter.sv
// ---------------------------------------------------------------------------
// yuv411_to_rgb_converter
// 4:1:1 YCbCr chunk to four RGB pixels, BT.601 signed 12.16 fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   input channel : i_in_valid / o_in_stall carry one chunk (four luma bytes,
//                   shared Cb and Cr) in i_in_item
//   output channel: o_out_valid / i_out_stall carry four clamped RGB pixels
//                   in o_out_item
//   an item moves at a clock edge where valid is high and stall is low
// Path: an accepted item loads the product register, then the output
//   register after the sums and clamp, which drives o_out_valid.
// Throughput: one item per cycle while the output is not stalled; four lanes
//   compute the four pixels in parallel off one shared set of chroma products.
// Stall: when the receiver stalls, the output item holds and the product
//   stage still takes one more item; o_in_stall rises only when both
//   stages are full and the output is stalled.
// Reset: synchronous, active low; empties both stages, so no item held before
//   reset is shown afterwards; payload registers are not cleared.
// ---------------------------------------------------------------------------
module yuv411_to_rgb_converter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  yuv2rgb_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output yuv2rgb_pkg::t_out_item o_out_item
);
    import yuv2rgb_pkg::*;

    logic                       r_s1_valid;
    logic                       r_out_valid;
    logic                       advance;
    logic                       s1_load;
    logic [LANES-1:0][7:0]      lumas;
    t_chroma_terms              terms;
    t_pixel [LANES-1:0]         pixels;

    // output register frees when empty or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || advance;
    assign o_in_stall = !s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign lumas[0] = i_in_item.luma_0;
    assign lumas[1] = i_in_item.luma_1;
    assign lumas[2] = i_in_item.luma_2;
    assign lumas[3] = i_in_item.luma_3;

    yuv2rgb_chroma u_chroma (
        .i_clk   (i_clk),
        .i_load  (s1_load),
        .i_cb    (i_in_item.chroma_blue),
        .i_cr    (i_in_item.chroma_red),
        .o_terms (terms)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        yuv2rgb_lane u_lane (
            .i_clk   (i_clk),
            .i_load  (s1_load),
            .i_luma  (lumas[k]),
            .i_terms (terms),
            .o_pixel (pixels[k])
        );
    end

    yuv2rgb_merge u_merge (
        .i_clk    (i_clk),
        .i_load   (advance),
        .i_pixels (pixels),
        .o_item   (o_out_item)
    );

    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/yuv2rgb_checker.sv
// ---------------------------------------------------------------------------
// yuv2rgb_checker
// Port-level checks of the converter's pipeline control, bound to the top.
// ---------------------------------------------------------------------------
`include "yuv411_to_rgb_converter_defines.svh"

module yuv2rgb_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input yuv2rgb_pkg::t_out_item o_out_item
);
    import yuv2rgb_pkg::*;

    logic in_accept;
    logic out_held;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_held  = o_out_valid && i_out_stall;

    // a stalled result holds its value
    `YUV_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(o_out_item), "output not held")

    // the input side only stalls behind a stalled output
    `YUV_ASSERT_NOW(a_stall_cause, o_in_stall, out_held, "stall without output backpressure")

    // an accepted item passes the product and output registers into o_out_valid when the output is not stalled
    `YUV_ASSERT_NEXT(a_latency, in_accept ##1 !i_out_stall, o_out_valid, "item did not arrive")

    // nothing is shown right after reset
    `YUV_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !o_out_valid, "output valid after reset")

endmodule

bind yuv411_to_rgb_converter yuv2rgb_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: sim/tb_yuv411_to_rgb_converter.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_yuv411_to_rgb_converter
// Self-checking bench for the 4:1:1 chunk to RGB converter: directed corner
// chunks and random chunks go in with random gaps, outputs are stalled at
// random, and each output item is checked against a built-in fixed-point
// model of the BT.601 conversion.
// ---------------------------------------------------------------------------
module tb_yuv411_to_rgb_converter;
    import yuv2rgb_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_CHUNKS = 1600;
    localparam int MAX_WAIT      = 13;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_REPORTS   = 10;

    localparam int K_Y    = 76310;
    localparam int K_RV   = 104635;
    localparam int K_GU   = -25690;
    localparam int K_GV   = -53294;
    localparam int K_BU   = 132278;
    localparam int Y_BASE = 16;
    localparam int C_MID  = 128;
    localparam int BYTE_MAX = 255;

    localparam string FIELD_NAMES [12] = '{
        "red_0", "green_0", "blue_0", "red_1", "green_1", "blue_1",
        "red_2", "green_2", "blue_2", "red_3", "green_3", "blue_3"
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    t_in_item  chunk_queue [$];
    t_out_item rgb_expected [$];
    int        bad_fields = 0;
    int        idle_cycles = 0;

    yuv411_to_rgb_converter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // floor by 2^16 then saturate to a byte
    function automatic logic [7:0] clamp_byte(input int sum);
        int q;
        q = sum >>> 16;
        if (q < 0) begin
            return 8'd0;
        end else if (q > BYTE_MAX) begin
            return 8'hff;
        end
        return q[7:0];
    endfunction

    function automatic t_out_item rgb_of_chunk(input t_in_item c);
        int         u;
        int         v;
        int         ly;
        int         lum [4];
        t_pixel     pix [4];
        u = c.chroma_blue;
        u -= C_MID;
        v = c.chroma_red;
        v -= C_MID;
        lum = '{c.luma_0, c.luma_1, c.luma_2, c.luma_3};
        for (int k = 0; k < LANES; k++) begin
            ly = K_Y * (lum[k] - Y_BASE);
            pix[k].red   = clamp_byte(K_RV * v + ly);
            pix[k].green = clamp_byte(K_GU * u + K_GV * v + ly);
            pix[k].blue  = clamp_byte(K_BU * u + ly);
        end
        return {pix[0], pix[1], pix[2], pix[3]};
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [6] = '{8'd0, 8'd15, 8'd16, 8'd128, 8'd235, 8'd255};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 5)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_chunk(input logic [7:0] l0, input logic [7:0] l1,
                               input logic [7:0] l2, input logic [7:0] l3,
                               input logic [7:0] cb, input logic [7:0] cr);
        t_in_item c;
        c.luma_0      = l0;
        c.luma_1      = l1;
        c.luma_2      = l2;
        c.luma_3      = l3;
        c.chroma_blue = cb;
        c.chroma_red  = cr;
        chunk_queue.push_back(c);
    endtask

    task automatic check_rgb(input t_out_item got);
        t_out_item   want;
        logic [95:0] w;
        logic [95:0] g;
        if (rgb_expected.size() == 0) begin
            bad_fields++;
            if (bad_fields <= MAX_REPORTS) begin
                $display("unexpected output item %h", got);
            end
            return;
        end
        want = rgb_expected.pop_front();
        w = want;
        g = got;
        for (int i = 0; i < 12; i++) begin
            if (g[95 - 8 * i -: 8] !== w[95 - 8 * i -: 8]) begin
                bad_fields++;
                if (bad_fields <= MAX_REPORTS) begin
                    $display("%s mismatch: expected %0d, got %0d", FIELD_NAMES[i],
                             w[95 - 8 * i -: 8], g[95 - 8 * i -: 8]);
                end
            end
        end
    endtask

    // driver: one chunk per handshake, random gap after each outside burst mode
    int  send_gap = 0;
    bit  send_burst = 1'b0;
    always @(posedge i_clk) begin
        logic     busy;
        logic     valid_next;
        t_in_item next_item;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            busy = in_valid;
            valid_next = in_valid;
            next_item = in_item;
            if (in_valid && !in_stall) begin
                rgb_expected.push_back(rgb_of_chunk(in_item));
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    valid_next = 1'b0;
                end else if (chunk_queue.size() > 0) begin
                    next_item = chunk_queue.pop_front();
                    valid_next = 1'b1;
                    if ($urandom_range(0, 49) == 0) begin
                        send_burst = !send_burst;
                    end
                    send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
                end else begin
                    valid_next = 1'b0;
                end
            end
            in_valid <= valid_next;
            in_item  <= next_item;
        end
    end

    // monitor: checks each output item, then holds stall for a random time
    int  stall_left = 0;
    bit  recv_burst = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                check_rgb(out_item);
                if ($urandom_range(0, 49) == 0) begin
                    recv_burst = !recv_burst;
                end
                stall_left = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        // black, white, all-zero, all-ones and luma around its offset
        queue_chunk(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_chunk(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_chunk(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128);
        queue_chunk(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128);
        queue_chunk(8'd0, 8'd15, 8'd16, 8'd17, 8'd128, 8'd128);
        // chroma corners and edges, mixed patterns, then random chunks
        queue_chunk(8'd255, 8'd235, 8'd128, 8'd0, 8'd0, 8'd0);
        queue_chunk(8'd255, 8'd235, 8'd128, 8'd0, 8'd0, 8'd255);
        queue_chunk(8'd255, 8'd235, 8'd128, 8'd0, 8'd255, 8'd0);
        queue_chunk(8'd255, 8'd235, 8'd128, 8'd0, 8'd255, 8'd255);
        queue_chunk(8'd0, 8'd85, 8'd170, 8'd255, 8'd128, 8'd0);
        queue_chunk(8'd0, 8'd85, 8'd170, 8'd255, 8'd128, 8'd255);
        queue_chunk(8'd16, 8'd16, 8'd16, 8'd16, 8'd0, 8'd128);
        queue_chunk(8'd16, 8'd16, 8'd16, 8'd16, 8'd255, 8'd128);
        queue_chunk(8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55);
        queue_chunk(8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa);
        queue_chunk(8'd128, 8'd128, 8'd128, 8'd128, 8'd127, 8'd129);
        queue_chunk(8'd81, 8'd145, 8'd41, 8'd210, 8'd90, 8'd240);
        for (int n = 0; n < RANDOM_CHUNKS; n++) begin
            queue_chunk(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                        pick_byte(), pick_byte());
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (chunk_queue.size() != 0 || in_valid || rgb_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_fields == 0 && rgb_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/yuv2rgb_pkg.sv
sv/yuv2rgb_chroma.sv
sv/yuv2rgb_lane.sv
sv/yuv2rgb_merge.sv
sv/yuv411_to_rgb_converter.sv
sv/yuv2rgb_checker.sv
sim/tb_yuv411_to_rgb_converter.sv
